@@ rtl/ecve_pkg.sv @@
package ecve_pkg;

	// fixed block configuration
	localparam int HIST_DEPTH    = 16;
	localparam int SLOT_W        = 4;
	localparam int AVG_SPAN      = 8;
	localparam int STEP_MS       = 10;
	localparam int TICKS_PER_REV = 225;
	localparam int STEPS_PER_MIN = 60000 / STEP_MS;
	localparam int SCALE         = STEPS_PER_MIN * 256;

	localparam int POS_W  = 32;
	localparam int STEP_W = 31;
	localparam int ENTRY_W = POS_W + STEP_W;
	localparam int CNT_W  = 4;     // walk index, span and count, 0..AVG_SPAN
	localparam int SUM_W  = 35;    // sum of up to AVG_SPAN signed 32-bit deltas
	localparam int LO_W   = 18;    // low partial product split of |sum|
	localparam int MAG_W  = 56;
	localparam int NUM_W  = 58;    // 2*mag + den
	localparam int DEN_W  = 11;    // count * TICKS_PER_REV
	localparam int DVS_W  = 12;    // 2 * den
	localparam int DCNT_W = 6;

	// event codes
	localparam logic [1:0] FUNC_A   = 2'd0;
	localparam logic [1:0] FUNC_B   = 2'd1;
	localparam logic [1:0] FUNC_CLR = 2'd2;
	localparam logic [1:0] FUNC_QRY = 2'd3;

	// register indexes
	localparam logic [1:0] REG_REV = 2'd0;
	localparam logic [1:0] REG_A   = 2'd1;
	localparam logic [1:0] REG_B   = 2'd2;

	typedef struct packed {
		logic accept;
		logic rd_last;
		logic wr_slot;
		logic clr_walk;
		logic rd_e;
		logic ld_e;
		logic rd_s;
		logic chk_s;
		logic mul_lo;
		logic mul_hi;
		logic mk_mag;
		logic mk_num;
		logic div_step;
		logic load_out;
	} ecve_cmd_t;

	typedef struct packed {
		logic is_a;
		logic ring_ready;
		logic e_fail;
		logic match;
		logic walk_more;
		logic j_more;
		logic cnt_zero;
		logic div_last;
		logic out_free;
	} ecve_sts_t;

endpackage

@@ rtl/encoder_count_velocity_estimator_unit.sv @@
// Quadrature encoder counter with velocity estimate. Each input word carries an
// event (A edge, B edge, clear count, query) and the current time step; each
// gives exactly one result word with the signed tick count, the speed in RPM
// as signed Q8 (saturated, zero until the 16-slot history ring has wrapped to
// slot zero) and that ready flag. A edges record position and step into the
// ring in a dual-port RAM (one write port, one registered read port). One word
// is processed at a time: bookkeeping, then the velocity walk, where each ring
// entry read has an address state and a data state (at most 13 reads for an
// 8-step span), then a split multiply and a radix-2 restoring divider when the
// walk finds a span. A finished result sits in the output register while the
// next word is accepted. Config writes are accepted every cycle and must only
// be issued while the block is idle; writing an initial level also loads the
// live channel level.
module encoder_count_velocity_estimator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [30:0] current_step, [31] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] position_count, [63:32] speed_rpm_q8
	output logic [0:0]  m_axis_tuser,   // [0] speed_valid
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,      // 0 reverse, 1 initial A, 2 initial B
	input  logic        cfg_data
);
	import ecve_pkg::*;

	ecve_cmd_t cmd;
	ecve_sts_t sts;

	assign cfg_ready = 1'b1;

	ecve_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ecve_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_func   (s_axis_tuser),
		.in_step   (s_axis_tdata[30:0]),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_val   (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pos   (m_axis_tdata[31:0]),
		.out_speed (m_axis_tdata[63:32]),
		.out_flag  (m_axis_tuser[0])
	);

endmodule

@@ rtl/ecve_ram.sv @@
module ecve_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/ecve_ctrl.sv @@
module ecve_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ecve_pkg::ecve_sts_t   sts,
	output ecve_pkg::ecve_cmd_t   cmd
);
	import ecve_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RLAST = 4'd1;
	localparam logic [3:0] S_WRITE = 4'd2;
	localparam logic [3:0] S_WALK0 = 4'd3;
	localparam logic [3:0] S_RE    = 4'd4;
	localparam logic [3:0] S_DE    = 4'd5;
	localparam logic [3:0] S_RS    = 4'd6;
	localparam logic [3:0] S_DS    = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_MH    = 4'd9;
	localparam logic [3:0] S_MAG   = 4'd10;
	localparam logic [3:0] S_NUM   = 4'd11;
	localparam logic [3:0] S_DIV   = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd13;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_RLAST;
				end
			end
			S_RLAST: begin
				if (sts.is_a) begin
					cmd.rd_last = 1'b1;
					state_d     = S_WRITE;
				end else begin
					state_d = S_WALK0;
				end
			end
			S_WRITE: begin
				cmd.wr_slot = 1'b1;
				state_d     = S_WALK0;
			end
			S_WALK0: begin
				cmd.clr_walk = 1'b1;
				state_d      = sts.ring_ready ? S_RE : S_OUT;
			end
			S_RE: begin
				cmd.rd_e = 1'b1;
				state_d  = S_DE;
			end
			S_DE: begin
				cmd.ld_e = 1'b1;
				state_d  = sts.e_fail ? S_FIN : S_RS;
			end
			S_RS: begin
				cmd.rd_s = 1'b1;
				state_d  = S_DS;
			end
			S_DS: begin
				cmd.chk_s = 1'b1;
				if (sts.match) begin
					state_d = sts.walk_more ? S_RE : S_FIN;
				end else begin
					state_d = sts.j_more ? S_RS : S_FIN;
				end
			end
			S_FIN: begin
				if (sts.cnt_zero) begin
					state_d = S_OUT;
				end else begin
					cmd.mul_lo = 1'b1;
					state_d    = S_MH;
				end
			end
			S_MH: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_MAG;
			end
			S_MAG: begin
				cmd.mk_mag = 1'b1;
				state_d    = S_NUM;
			end
			S_NUM: begin
				cmd.mk_num = 1'b1;
				state_d    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q == S_RLAST))
		else $error("accepted word did not start processing");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !sts.out_free) |=> (state_q == S_OUT))
		else $error("result left while output register was full");

endmodule

@@ rtl/ecve_dp.sv @@
module ecve_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ecve_pkg::ecve_cmd_t   cmd,
	output ecve_pkg::ecve_sts_t   sts,
	input  logic [1:0]            in_func,
	input  logic [30:0]           in_step,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_idx,
	input  logic                  cfg_val,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           out_pos,
	output logic [31:0]           out_speed,
	output logic                  out_flag
);
	import ecve_pkg::*;

	logic [1:0]          func_q;
	logic [STEP_W-1:0]   cur_q;
	logic                a_q, b_q, rev_q;
	logic [POS_W-1:0]    tick_q;
	logic [SLOT_W-1:0]   last_q;
	logic                ready_q;
	logic [HIST_DEPTH-1:0] vld_q;
	logic                rd_vld_q;
	logic [CNT_W-1:0]    i_q, j_q, cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [STEP_W-1:0]   e_step_q;
	logic [POS_W-1:0]    e_pos_q;
	logic [LO_W+20:0]    plo_q;
	logic [MAG_W-LO_W-1:0] phi_q;
	logic [MAG_W-1:0]    mag_q;
	logic [NUM_W-1:0]    num_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DCNT_W-1:0]   dcnt_q;

	logic [SLOT_W-1:0]   rd_addr, new_slot;
	logic [ENTRY_W-1:0]  rdata;
	logic [STEP_W-1:0]   rd_step;
	logic [POS_W-1:0]    rd_pos, dpos;
	logic [31:0]         step_diff;
	logic [SUM_W-1:0]    abs_sum;
	logic [DEN_W-1:0]    den;
	logic [DVS_W-1:0]    dvs;
	logic [DVS_W:0]      rem_sh;
	logic                ge;
	logic                neg;
	logic [31:0]         sat;

	// slot arithmetic wraps in SLOT_W bits (depth is a power of two)
	always_comb begin
		if (cmd.rd_s) begin
			rd_addr = last_q - i_q - j_q;
		end else if (cmd.rd_e) begin
			rd_addr = last_q - i_q;
		end else begin
			rd_addr = last_q;
		end
	end

	ecve_ram #(.WIDTH(ENTRY_W), .DEPTH(HIST_DEPTH)) u_ring (
		.clk   (clk),
		.we    (cmd.wr_slot),
		.waddr (new_slot),
		.wdata ({cur_q, tick_q}),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// never-written entries read as zero
	assign rd_step  = rd_vld_q ? rdata[ENTRY_W-1:POS_W] : '0;
	assign rd_pos   = rd_vld_q ? rdata[POS_W-1:0] : '0;
	assign new_slot = last_q + cur_q[SLOT_W-1:0] - rd_step[SLOT_W-1:0];

	assign step_diff = {1'b0, e_step_q} - {1'b0, rd_step};
	assign dpos      = e_pos_q - rd_pos;
	assign abs_sum   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign den       = DEN_W'(cnt_q) * DEN_W'(TICKS_PER_REV);
	assign dvs       = {den, 1'b0};
	assign rem_sh    = {rem_q, num_q[NUM_W-1]};
	assign ge        = rem_sh >= {1'b0, dvs};

	always_comb begin
		neg = sum_q[SUM_W-1] ^ rev_q;
		if (neg) begin
			sat = (num_q > NUM_W'(64'h8000_0000)) ? 32'h8000_0000 : 32'(-num_q);
		end else begin
			sat = (num_q > NUM_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : num_q[31:0];
		end
	end

	assign sts.is_a       = (func_q == FUNC_A);
	assign sts.ring_ready = ready_q;
	assign sts.e_fail     = ({1'b0, cur_q} > ({1'b0, rd_step} + 32'(AVG_SPAN)))
		|| !(({2'b0, i_q} + 6'd2) < 6'(AVG_SPAN));
	assign sts.match      = (step_diff == 32'(j_q));
	assign sts.walk_more  = ({1'b0, i_q} + {1'b0, j_q}) < 5'(AVG_SPAN);
	assign sts.j_more     = ({2'b0, i_q} + {2'b0, j_q} + 6'd2) < 6'(AVG_SPAN);
	assign sts.cnt_zero   = (cnt_q == '0);
	assign sts.div_last   = (dcnt_q == DCNT_W'(NUM_W - 1));
	assign sts.out_free   = !out_valid || out_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q    <= FUNC_QRY;
			a_q       <= 1'b0;
			b_q       <= 1'b0;
			rev_q     <= 1'b0;
			tick_q    <= '0;
			last_q    <= '0;
			ready_q   <= 1'b0;
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			cnt_q     <= '0;
			dcnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (cfg_we) begin
				case (cfg_idx)
					REG_REV: rev_q <= cfg_val;
					REG_A:   a_q   <= cfg_val;
					REG_B:   b_q   <= cfg_val;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				func_q <= in_func;
				case (in_func)
					FUNC_A: begin
						a_q    <= ~a_q;
						tick_q <= (~a_q != b_q) ? tick_q + 1'b1 : tick_q - 1'b1;
					end
					FUNC_B:   b_q    <= ~b_q;
					FUNC_CLR: tick_q <= '0;
					default: ;
				endcase
			end
			if (cmd.wr_slot) begin
				vld_q[new_slot] <= 1'b1;
				last_q          <= new_slot;
				if (new_slot == '0) begin
					ready_q <= 1'b1;
				end
			end
			if (cmd.clr_walk) begin
				i_q   <= '0;
				cnt_q <= '0;
			end
			if (cmd.ld_e) begin
				j_q <= CNT_W'(1);
			end
			if (cmd.chk_s) begin
				if (sts.match) begin
					i_q   <= i_q + j_q;
					cnt_q <= cnt_q + j_q;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			if (cmd.mk_num) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q <= in_step;
		end
		if (cmd.clr_walk) begin
			sum_q <= '0;
		end else if (cmd.chk_s && sts.match) begin
			sum_q <= sum_q + SUM_W'(signed'(dpos));
		end
		if (cmd.ld_e) begin
			e_step_q <= rd_step;
			e_pos_q  <= rd_pos;
		end
		if (cmd.mul_lo) begin
			plo_q <= (LO_W+21)'(abs_sum[LO_W-1:0]) * (LO_W+21)'(SCALE);
		end
		if (cmd.mul_hi) begin
			phi_q <= (MAG_W-LO_W)'(abs_sum[SUM_W-1:LO_W]) * (MAG_W-LO_W)'(SCALE);
		end
		if (cmd.mk_mag) begin
			mag_q <= MAG_W'(plo_q) + {phi_q, {LO_W{1'b0}}};
		end
		if (cmd.mk_num) begin
			num_q <= {1'b0, mag_q, 1'b0} + NUM_W'(den);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			// restoring division, quotient shifts in behind the dividend
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
		if (cmd.load_out) begin
			out_pos   <= rev_q ? (32'd0 - tick_q) : tick_q;
			out_speed <= sts.cnt_zero ? 32'd0 : sat;
			out_flag  <= ready_q;
		end
	end

	a_count_tracks_index: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == i_q)
		else $error("span count diverged from walk index");

	a_ready_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> vld_q[0])
		else $error("ring ready without slot zero written");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.chk_s && sts.match |=> (i_q <= CNT_W'(AVG_SPAN)))
		else $error("walk index ran past span");

endmodule
